// ----- src/hht_pkg.sv -----
// Shared types and constants for the humidity heater trigger sequencer.
// No dependencies; imported by every module under src.
package hht_pkg;

    // Field widths
    localparam int HUM_W        = 18;
    localparam int TEMP_W       = 18;
    localparam int HUM_TRIG_W   = 17;
    localparam int TRIG_CNT_W   = 4;
    localparam int MARGIN_W     = 16;
    localparam int BASELINE_W   = 19;
    localparam int ACTION_W     = 2;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 19;

    // Window depth default
    localparam int WINDOW_DEPTH_DEF = 10;

    // Register reset values
    localparam logic [HUM_TRIG_W-1:0] HUM_TRIG_RST = HUM_TRIG_W'(74000);
    localparam logic [TRIG_CNT_W-1:0] TRIG_CNT_RST = TRIG_CNT_W'(5);
    localparam logic [MARGIN_W-1:0]   MARGIN_RST   = MARGIN_W'(2000);
    localparam logic signed [BASELINE_W-1:0] BASELINE_RST = '0;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_TRIG = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_CNT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_BASELINE = CFG_INDEX_W'(3);

    // Sequence phases
    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_MEAS     = 3'd1,
        PH_PRETRIG  = 3'd2,
        PH_HEATING  = 3'd3,
        PH_COOLDOWN = 3'd4
    } phase_t;

    // Result codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE      = 2'd0,
        ACT_HEAT      = 2'd1,
        ACT_COOL_WAIT = 2'd2
    } action_t;

    // Configuration register set
    typedef struct packed {
        logic [HUM_TRIG_W-1:0]        hum_trig;
        logic [TRIG_CNT_W-1:0]        trig_cnt;
        logic [MARGIN_W-1:0]          margin;
        logic signed [BASELINE_W-1:0] baseline;
    } cfg_t;

endpackage

// ----- src/hht_window.sv -----
// Sliding window of per-sample high flags with running fill level and count.
// Depends on hht_pkg.
module hht_window
    import hht_pkg::*;
#(
    parameter int DEPTH   = WINDOW_DEPTH_DEF,
    parameter int COUNT_W = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               flag,
    output logic [COUNT_W-1:0] count_after
);

    logic [DEPTH-1:0]   flags_reg;
    logic [DEPTH-1:0]   flags_next;
    logic [COUNT_W-1:0] fill_reg;
    logic [COUNT_W-1:0] fill_next;
    logic [COUNT_W-1:0] count_reg;
    logic               full;
    logic               dropped;

    // Work out the window after this push
    always_comb
    begin
        full        = (fill_reg == COUNT_W'(DEPTH));
        dropped     = full & flags_reg[DEPTH-1];
        flags_next  = flags_reg << 1;
        flags_next[0] = flag;
        fill_next   = full ? fill_reg : fill_reg + COUNT_W'(1);
        count_after = count_reg - COUNT_W'(dropped) + COUNT_W'(flag);
    end

    // Advance the window on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            flags_reg <= flags_next;
            fill_reg  <= fill_next;
            count_reg <= count_after;
        end
    end

endmodule

// ----- src/hht_seq.sv -----
// Five-phase heater trigger sequence and result code decision.
// Depends on hht_pkg; takes the post-push window count from hht_window.
module hht_seq
    import hht_pkg::*;
#(
    parameter int COUNT_W = $clog2(WINDOW_DEPTH_DEF + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic signed [HUM_W-1:0]  humidity,
    input  logic signed [TEMP_W-1:0] main_temp,
    input  logic signed [TEMP_W-1:0] aux_temp,
    input  logic                     restart,
    input  logic [COUNT_W-1:0]       count_after,
    input  cfg_t                     cfg,
    output action_t                  action
);

    localparam int CMP_W  = ((COUNT_W > TRIG_CNT_W) ? COUNT_W : TRIG_CNT_W) + 1;
    localparam int HCMP_W = HUM_W + 1;
    localparam int DIFF_W = TEMP_W + 1;
    localparam int LIM_W  = BASELINE_W + 1;

    phase_t phase_reg;
    phase_t phase_next;

    logic signed [HCMP_W-1:0] hum_ext;
    logic signed [HCMP_W-1:0] trig_ext;
    logic signed [DIFF_W-1:0] diff;
    logic signed [LIM_W-1:0]  limit;
    logic                     hum_above;
    logic                     hum_below;
    logic                     count_met;
    logic                     cooled;

    // Compare humidity, window count and temperature difference
    always_comb
    begin
        hum_ext   = HCMP_W'(humidity);
        trig_ext  = $signed({2'b00, cfg.hum_trig});
        hum_above = hum_ext > trig_ext;
        hum_below = hum_ext < trig_ext;
        count_met = CMP_W'(count_after) >= CMP_W'(cfg.trig_cnt);
        diff      = DIFF_W'(main_temp) - DIFF_W'(aux_temp);
        limit     = LIM_W'(cfg.baseline) + $signed({{(LIM_W-MARGIN_W){1'b0}}, cfg.margin});
        cooled    = LIM_W'(diff) < limit;
    end

    // Next phase and result code
    always_comb
    begin
        phase_next = phase_reg;
        action     = ACT_NONE;
        if (restart)
        begin
            phase_next = PH_INIT;
        end
        else
        begin
            unique case (phase_reg)
                PH_MEAS:
                begin
                    if (hum_above)
                        phase_next = PH_PRETRIG;
                end
                PH_PRETRIG:
                begin
                    if (hum_below)
                        phase_next = PH_MEAS;
                    else if (count_met)
                    begin
                        phase_next = PH_HEATING;
                        action     = ACT_HEAT;
                    end
                end
                PH_HEATING:
                begin
                    phase_next = PH_COOLDOWN;
                end
                PH_COOLDOWN:
                begin
                    if (cooled)
                        phase_next = PH_MEAS;
                    else
                        action = ACT_COOL_WAIT;
                end
                default:
                begin
                    phase_next = PH_MEAS;
                end
            endcase
        end
    end

    // Hold the phase between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_INIT;
        else if (step)
            phase_reg <= phase_next;
    end

endmodule

// ----- src/humidity_heater_trigger_fsm.sv -----
// Top level of the humidity heater trigger sequencer: input register,
// configuration registers, result register. Depends on hht_pkg, hht_window, hht_seq.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, humidity, main_temp, | sink
//          | aux_temp, restart                        |
//  out     | out_valid, out_ready, action             | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
// One item per cycle sustained while the result is not stalled; an accepted item moves
// from the input register into the result register, where its result is valid.
// The window update and phase step are done in the single cycle that moves an
// item from the input register into the result register.
// Reset clears the phase to init, empties the window and loads register defaults.
// A stalled result holds the input register; cfg_ready is always high.
module humidity_heater_trigger_fsm
    import hht_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [HUM_W-1:0]       humidity,
    input  logic signed [TEMP_W-1:0]      main_temp,
    input  logic signed [TEMP_W-1:0]      aux_temp,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ACTION_W-1:0]           action,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);

    cfg_t cfg_reg;

    logic                     in_valid_reg;
    logic signed [HUM_W-1:0]  hum_reg;
    logic signed [TEMP_W-1:0] tmain_reg;
    logic signed [TEMP_W-1:0] taux_reg;
    logic                     restart_reg;

    logic                     out_valid_reg;
    action_t                  action_reg;

    logic                     advance;
    logic                     step;
    logic                     flag;
    logic [COUNT_W-1:0]       count_after;
    action_t                  action_next;

    // Handshake control
    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign action    = action_reg;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hum_trig <= HUM_TRIG_RST;
            cfg_reg.trig_cnt <= TRIG_CNT_RST;
            cfg_reg.margin   <= MARGIN_RST;
            cfg_reg.baseline <= BASELINE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HUM_TRIG: cfg_reg.hum_trig <= cfg_data[HUM_TRIG_W-1:0];
                REG_TRIG_CNT: cfg_reg.trig_cnt <= cfg_data[TRIG_CNT_W-1:0];
                REG_MARGIN:   cfg_reg.margin   <= cfg_data[MARGIN_W-1:0];
                REG_BASELINE: cfg_reg.baseline <= $signed(cfg_data[BASELINE_W-1:0]);
                default:      ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hum_reg     <= humidity;
            tmain_reg   <= main_temp;
            taux_reg    <= aux_temp;
            restart_reg <= restart;
        end
    end

    // Flag a sample that is below -1 or above the trigger level
    assign flag = (hum_reg < HUM_W'(-1)) ||
                  ($signed({hum_reg[HUM_W-1], hum_reg}) > $signed({2'b00, cfg_reg.hum_trig}));

    hht_window #(
        .DEPTH   (WINDOW_DEPTH),
        .COUNT_W (COUNT_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (step),
        .flag        (flag),
        .count_after (count_after)
    );

    hht_seq #(
        .COUNT_W (COUNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .humidity    (hum_reg),
        .main_temp   (tmain_reg),
        .aux_temp    (taux_reg),
        .restart     (restart_reg),
        .count_after (count_after),
        .cfg         (cfg_reg),
        .action      (action_next)
    );

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (step)
            action_reg <= action_next;
    end

endmodule
